// ----- sv/rcst_pkg.sv -----
// Shared types and constants for the chunk slot tracker.
// No dependencies; imported by every other file.
`timescale 1ns / 1ps
`default_nettype none
package rcst_pkg;
   localparam int SLOTS     = 16;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int MAX_CHUNK = 1024;
   localparam int LEN_W     = 11;
   localparam int ID_W      = 32;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 8;

   typedef enum logic [1:0] {ST_FREE, ST_QUEUED, ST_WAIT} slot_state_type;

   localparam logic [1:0] REQ_NEW      = 2'd0;
   localparam logic [1:0] REQ_DISPATCH = 2'd1;
   localparam logic [1:0] REQ_CONFIRM  = 2'd2;
   localparam logic [1:0] REQ_TICK     = 2'd3;

   localparam logic [1:0] OUT_ACCEPTED = 2'd0;
   localparam logic [1:0] OUT_REJECTED = 2'd1;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_NO_SLOT  = 2'd1;
   localparam logic [1:0] STS_Q_EMPTY  = 2'd2;
   localparam logic [1:0] STS_NO_ID    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_SLOTS   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RETRY   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CONFIRM = 8'd3;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [LEN_W-1:0] chunk_length;
      logic [1:0]       submit_outcome;
      logic [ID_W-1:0]  confirm_id;
      logic             confirm_retry;
   } req_txn_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [3:0]        slot_index;
      logic [ID_W-1:0]   message_id;
      logic [LEN_W-1:0]  length_out;
      logic              now_waiting;
      logic              requeued;
      logic              released;
      logic              dropped;
      logic [4:0]        expired_count;
   } rsp_txn_type;

   typedef struct packed {
      logic clear;
      logic alloc;
      logic set_wait;
      logic requeue;
      logic release_slot;
   } cell_cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]  msg_id;
      logic [LEN_W-1:0] len;
      logic [7:0]       limit;
      logic             flag;
      logic [31:0]      deadline;
   } cell_wr_type;

   typedef struct packed {
      slot_state_type   state;
      logic [7:0]       retries;
      logic [7:0]       limit;
      logic             flag;
      logic [ID_W-1:0]  msg_id;
      logic [LEN_W-1:0] len;
      logic             hit;
      logic             expired;
   } cell_view_type;
endpackage
`default_nettype wire

// ----- sv/reliable_chunk_slot_tracker.sv -----
// New chunk, dispatch and confirmation go from idle to S_RUN; the response is registered as S_RUN returns to idle.
// A tick passes S_RUN, then walks every slot in S_SCAN, one per cycle; the response is registered after the last slot.
// Throughput: one transaction at a time; busy holds off start until the response strobe.
// The response strobe lasts one cycle and cannot be stalled.
// Reset (synchronous): registers to defaults, all slots free, free list 0..SLOTS-1.
// Depends on rcst_pkg, rcst_cell, rcst_fifo.
`timescale 1ns / 1ps
`default_nettype none
module reliable_chunk_slot_tracker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  rcst_pkg::req_txn_type            req_data,
   output logic                             rsp_strobe,
   output rcst_pkg::rsp_txn_type            rsp_data,
   input  wire                              csr_we,
   input  wire [rcst_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [rcst_pkg::CSR_W-1:0]        csr_wdata
);
   import rcst_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_SCAN} fsm_type;

   fsm_type           fsm_ff;
   req_txn_type       req_ff;
   rsp_txn_type       rsp_ff, rsp_in;
   logic              rsp_strobe_ff;
   logic [7:0]        retry_limit_ff;
   logic [15:0]       timeout_ff;
   logic              need_confirm_ff;
   logic [ID_W-1:0]   last_id_ff;
   logic [31:0]       tick_ff;
   logic [SLOT_W-1:0] scan_idx_ff;
   logic [CNT_W-1:0]  exp_cnt_ff;

   // slot count write: clamp into 1..SLOTS; it only sets the free list fill,
   // slots above it stay free and never match or expire
   logic [CNT_W-1:0]  siu_new;
   logic              rebuild;
   logic [CNT_W-1:0]  free_init_count;

   // per-transaction control
   logic [SLOT_W-1:0] sel;
   logic              op_alloc, op_wait, op_requeue, op_release;
   logic              free_push, free_pop, up_push, up_pop;
   logic              done;
   logic              exp_inc;
   logic              can_retry;
   logic [LEN_W-1:0]  len_clamped;
   logic [ID_W-1:0]   next_id;

   logic [SLOT_W-1:0] free_head, up_head;
   logic [CNT_W-1:0]  free_count, up_count;

   cell_cmd_type      cmd   [SLOTS];
   cell_view_type     view  [SLOTS];
   cell_view_type     sview;
   cell_wr_type       wdata;
   logic [SLOTS:0]    chain;
   logic [SLOT_W-1:0] hit_idx;

   assign busy       = (fsm_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      siu_new = csr_wdata[CNT_W-1:0];
      if (siu_new == '0) begin
         siu_new = CNT_W'(1);
      end else if (siu_new > CNT_W'(SLOTS)) begin
         siu_new = CNT_W'(SLOTS);
      end
   end

   assign rebuild         = csr_we && (csr_index == REG_SLOTS);
   assign free_init_count = reset ? CNT_W'(SLOTS) : siu_new;

   // ---------------- slot row ----------------
   assign chain[0] = 1'b0;
   generate
      for (genvar g = 0; g < SLOTS; g++) begin : g_cell
         rcst_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd[g]),
            .wdata     (wdata),
            .cid       (req_ff.confirm_id),
            .tick_now  (tick_ff),
            .match_in  (chain[g]),
            .match_out (chain[g+1]),
            .view      (view[g])
         );
      end
   endgenerate

   // hits are one-hot, so OR the matching indices together
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (view[i].hit) begin
            hit_idx = hit_idx | SLOT_W'(i);
         end
      end
   end

   rcst_fifo u_free (
      .clock      (clock),
      .reset      (reset),
      .init       (rebuild),
      .init_count (free_init_count),
      .push       (free_push),
      .push_data  (sel),
      .pop        (free_pop),
      .head_data  (free_head),
      .count      (free_count)
   );

   rcst_fifo u_up (
      .clock      (clock),
      .reset      (reset),
      .init       (rebuild),
      .init_count ('0),
      .push       (up_push),
      .push_data  (sel),
      .pop        (up_pop),
      .head_data  (up_head),
      .count      (up_count)
   );

   assign len_clamped = (req_ff.chunk_length > LEN_W'(MAX_CHUNK)) ?
                        LEN_W'(MAX_CHUNK) : req_ff.chunk_length;
   assign next_id     = last_id_ff + ID_W'(1);

   always_comb begin
      wdata.msg_id   = next_id;
      wdata.len      = len_clamped;
      wdata.limit    = retry_limit_ff;
      wdata.flag     = need_confirm_ff;
      wdata.deadline = tick_ff + {16'd0, timeout_ff};
   end

   // Pick the slot this cycle works on, then what happens to it.
   always_comb begin
      sel = '0;
      unique case (fsm_ff)
         S_SCAN: sel = scan_idx_ff;
         S_RUN: begin
            unique case (req_ff.req_type)
               REQ_NEW:      sel = free_head;
               REQ_DISPATCH: sel = up_head;
               REQ_CONFIRM:  sel = hit_idx;
               REQ_TICK:     sel = '0;
            endcase
         end
         default: sel = '0;
      endcase
   end

   assign sview     = view[sel];
   assign can_retry = sview.retries < sview.limit;

   always_comb begin
      op_alloc   = 1'b0;
      op_wait    = 1'b0;
      op_requeue = 1'b0;
      op_release = 1'b0;
      free_pop   = 1'b0;
      up_pop     = 1'b0;
      done       = 1'b0;
      exp_inc    = 1'b0;
      rsp_in     = '0;
      if (fsm_ff == S_RUN) begin
         unique case (req_ff.req_type)
            REQ_NEW: begin
               done = 1'b1;
               if (free_count == '0) begin
                  rsp_in.status = STS_NO_SLOT;
               end else begin
                  op_alloc          = 1'b1;
                  free_pop          = 1'b1;
                  rsp_in.slot_index = 4'(sel);
                  rsp_in.message_id = next_id;
                  rsp_in.length_out = len_clamped;
               end
            end
            REQ_DISPATCH: begin
               done = 1'b1;
               if (up_count == '0) begin
                  rsp_in.status = STS_Q_EMPTY;
               end else begin
                  up_pop            = 1'b1;
                  rsp_in.slot_index = 4'(sel);
                  rsp_in.message_id = sview.msg_id;
                  rsp_in.length_out = sview.len;
                  if (req_ff.submit_outcome == OUT_ACCEPTED) begin
                     if (sview.flag) begin
                        op_wait            = 1'b1;
                        rsp_in.now_waiting = 1'b1;
                     end else begin
                        op_release      = 1'b1;
                        rsp_in.released = 1'b1;
                     end
                  end else if (req_ff.submit_outcome == OUT_REJECTED) begin
                     op_release      = 1'b1;
                     rsp_in.released = 1'b1;
                     rsp_in.dropped  = 1'b1;
                  end else if (can_retry) begin
                     op_requeue      = 1'b1;
                     rsp_in.requeued = 1'b1;
                  end else begin
                     op_release      = 1'b1;
                     rsp_in.released = 1'b1;
                     rsp_in.dropped  = 1'b1;
                  end
               end
            end
            REQ_CONFIRM: begin
               done = 1'b1;
               if (!chain[SLOTS]) begin
                  rsp_in.status = STS_NO_ID;
               end else begin
                  rsp_in.slot_index = 4'(sel);
                  rsp_in.message_id = sview.msg_id;
                  rsp_in.length_out = sview.len;
                  if (req_ff.confirm_retry && can_retry) begin
                     op_requeue      = 1'b1;
                     rsp_in.requeued = 1'b1;
                  end else if (req_ff.confirm_retry) begin
                     op_release      = 1'b1;
                     rsp_in.released = 1'b1;
                     rsp_in.dropped  = 1'b1;
                  end else begin
                     op_release      = 1'b1;
                     rsp_in.released = 1'b1;
                  end
               end
            end
            REQ_TICK: begin
               done = 1'b0;
            end
         endcase
      end else if (fsm_ff == S_SCAN) begin
         // expired slots are handled in index order, one per cycle: requeued while retries remain, else released
         if (sview.expired) begin
            exp_inc = 1'b1;
            if (can_retry) begin
               op_requeue = 1'b1;
            end else begin
               op_release = 1'b1;
            end
         end
         done                 = (scan_idx_ff == SLOT_W'(SLOTS - 1));
         rsp_in.expired_count = 5'(exp_cnt_ff + CNT_W'(exp_inc));
      end
   end

   assign free_push = op_release;
   assign up_push   = op_alloc || op_requeue;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         cmd[i].clear        = rebuild;
         cmd[i].alloc        = op_alloc   && (sel == SLOT_W'(i));
         cmd[i].set_wait     = op_wait    && (sel == SLOT_W'(i));
         cmd[i].requeue      = op_requeue && (sel == SLOT_W'(i));
         cmd[i].release_slot = op_release && (sel == SLOT_W'(i));
      end
   end

   // ---------------- sequencer and registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff          <= S_IDLE;
         rsp_strobe_ff   <= 1'b0;
         retry_limit_ff  <= 8'd3;
         timeout_ff      <= 16'd1000;
         need_confirm_ff <= 1'b0;
         last_id_ff      <= '0;
         tick_ff         <= '0;
         scan_idx_ff     <= '0;
         exp_cnt_ff      <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               REG_RETRY:   retry_limit_ff  <= csr_wdata[7:0];
               REG_TIMEOUT: timeout_ff      <= csr_wdata;
               REG_CONFIRM: need_confirm_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (op_alloc) begin
            last_id_ff <= next_id;
         end
         unique case (fsm_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  fsm_ff <= S_RUN;
               end
            end
            S_RUN: begin
               if (done) begin
                  rsp_ff        <= rsp_in;
                  rsp_strobe_ff <= 1'b1;
                  fsm_ff        <= S_IDLE;
               end else begin
                  tick_ff     <= tick_ff + 32'd1;
                  scan_idx_ff <= '0;
                  exp_cnt_ff  <= '0;
                  fsm_ff      <= S_SCAN;
               end
            end
            S_SCAN: begin
               exp_cnt_ff  <= exp_cnt_ff + CNT_W'(exp_inc);
               scan_idx_ff <= scan_idx_ff + SLOT_W'(1);
               if (done) begin
                  rsp_ff        <= rsp_in;
                  rsp_strobe_ff <= 1'b1;
                  fsm_ff        <= S_IDLE;
               end
            end
            default: fsm_ff <= S_IDLE;
         endcase
      end
   end

   // the free and upstream queues together never hold more than SLOTS slots
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(free_count) + 32'(up_count)) <= SLOTS)
      else $error("free and upstream counts exceed slot count");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a transaction in progress");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (!up_pop || (up_count != '0)) && (!free_pop || (free_count != '0)))
      else $error("pop from empty slot queue");
endmodule
`default_nettype wire

// ----- sv/rcst_cell.sv -----
// One slot of the tracker: state, retry count and message fields.
// Depends on rcst_pkg. Passes the id-match chain to the next cell.
`timescale 1ns / 1ps
`default_nettype none
module rcst_cell (
   input  wire                         clock,
   input  wire                         reset,
   input  rcst_pkg::cell_cmd_type      cmd,
   input  rcst_pkg::cell_wr_type       wdata,
   input  wire [rcst_pkg::ID_W-1:0]    cid,
   input  wire [31:0]                  tick_now,
   input  wire                         match_in,
   output logic                        match_out,
   output rcst_pkg::cell_view_type     view
);
   import rcst_pkg::*;

   slot_state_type   state_ff, state_in;
   logic [7:0]       retries_ff;
   logic [7:0]       limit_ff;
   logic             flag_ff;
   logic [ID_W-1:0]  msg_id_ff;
   logic [LEN_W-1:0] len_ff;
   logic [31:0]      deadline_ff;
   logic [31:0]      age;
   logic             match;

   always_comb begin
      state_in = state_ff;
      priority if (cmd.clear) begin
         state_in = ST_FREE;
      end else if (cmd.alloc || cmd.requeue) begin
         state_in = ST_QUEUED;
      end else if (cmd.set_wait) begin
         state_in = ST_WAIT;
      end else if (cmd.release_slot) begin
         state_in = ST_FREE;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FREE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         msg_id_ff  <= wdata.msg_id;
         len_ff     <= wdata.len;
         limit_ff   <= wdata.limit;
         flag_ff    <= wdata.flag;
         retries_ff <= 8'd0;
      end else if (cmd.requeue) begin
         retries_ff <= retries_ff + 8'd1;
      end
      if (cmd.set_wait) begin
         deadline_ff <= wdata.deadline;
      end
   end

   assign age       = tick_now - deadline_ff;
   assign match     = (state_ff == ST_WAIT) && (msg_id_ff == cid);
   assign match_out = match_in | match;

   always_comb begin
      view.state   = state_ff;
      view.retries = retries_ff;
      view.limit   = limit_ff;
      view.flag    = flag_ff;
      view.msg_id  = msg_id_ff;
      view.len     = len_ff;
      view.hit     = match & ~match_in;
      view.expired = (state_ff == ST_WAIT) && !age[31];
   end
endmodule
`default_nettype wire

// ----- sv/rcst_fifo.sv -----
// Slot index FIFO with head pointer and count; init loads 0..N-1.
// Depends on rcst_pkg. Used for the free list and the upstream queue.
`timescale 1ns / 1ps
`default_nettype none
module rcst_fifo (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          init,
   input  wire [rcst_pkg::CNT_W-1:0]    init_count,
   input  wire                          push,
   input  wire [rcst_pkg::SLOT_W-1:0]   push_data,
   input  wire                          pop,
   output logic [rcst_pkg::SLOT_W-1:0]  head_data,
   output logic [rcst_pkg::CNT_W-1:0]   count
);
   import rcst_pkg::*;

   logic [SLOT_W-1:0] entry_ff [SLOTS];
   logic [SLOT_W-1:0] head_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [SLOT_W-1:0] tail;

   assign tail      = head_ff + count_ff[SLOT_W-1:0];
   assign head_data = entry_ff[head_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (reset || init) begin
         for (int i = 0; i < SLOTS; i++) begin
            entry_ff[i] <= SLOT_W'(i);
         end
         head_ff  <= '0;
         count_ff <= init_count;
      end else begin
         if (push) begin
            entry_ff[tail] <= push_data;
         end
         if (pop) begin
            head_ff <= head_ff + SLOT_W'(1);
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end
endmodule
`default_nettype wire
